// ----- rtl/sha256_byte_stream_hasher_core_assert.svh -----
// Assertion macros for the SHA-256 byte stream hasher.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SHA256_BYTE_STREAM_HASHER_CORE_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sha256_pkg.sv -----
// Shared types, constants and round functions of the SHA-256 hasher.
// Depends on nothing; used by the controller, datapath and top level.
package sha256_pkg;

  localparam int ROUNDS    = 64;
  localparam int RND_W     = $clog2(ROUNDS);
  localparam int BLK_BYTES = 64;
  localparam int POS_W     = $clog2(BLK_BYTES);
  localparam int CNT_W     = 61;
  localparam int LEN_W     = 64;
  localparam int DIG_W     = 256;
  localparam int BLK_W     = 512;

  localparam logic [7:0]       PAD_BYTE = 8'h80;
  localparam logic [POS_W-1:0] LEN_POS  = POS_W'(56);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLK_BYTES - 1);
  localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUNDS - 1);

  localparam logic [31:0] K_TAB [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Source of the byte shifted into the block window.
  typedef enum logic [1:0] {
    SRC_IN   = 2'd0,
    SRC_PAD  = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LEN  = 2'd3
  } src_t;

  typedef struct packed {
    logic shift_en;   // shift one byte into the window
    src_t src;
    logic cnt_inc;    // count a message byte
    logic len_load;   // capture bit length, clear byte count
    logic blk_start;  // load working vars, clear round counter
    logic round_en;   // run one compression round
    logic chain_add;  // fold working vars into chain words
    logic emit;       // load output register, restore initial chain
  } dp_cmd_t;

  typedef struct packed {
    logic fpos_last;  // next byte fills the block
    logic fpos_len;   // block position where the length starts
    logic round_last;
    logic out_busy;   // output register holds an untaken digest
  } dp_sts_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ----- rtl/sha256_dp.sv -----
// Datapath of the SHA-256 hasher: block window, schedule, round unit, chain and output.
// Depends on sha256_pkg; driven by sha256_ctrl through dp_cmd_t.
module sha256_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sha256_pkg::dp_cmd_t               cmd,
  output sha256_pkg::dp_sts_t               sts,
  input  logic [7:0]                        in_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sha256_pkg::DIG_W-1:0]      out_data
);

  logic [sha256_pkg::BLK_W-1:0] win_r, win_nxt;
  logic [sha256_pkg::POS_W-1:0] fpos_r, fpos_nxt;
  logic [sha256_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [sha256_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [sha256_pkg::RND_W-1:0] rnd_r, rnd_nxt;
  logic [31:0]                  work_r [8];
  logic [31:0]                  work_nxt [8];
  logic [31:0]                  chain_r [8];
  logic [31:0]                  chain_nxt [8];
  logic [sha256_pkg::DIG_W-1:0] out_r, out_nxt;
  logic                         out_valid_r, out_valid_nxt;

  logic [7:0]  shift_byte;
  logic [31:0] w0, w1, w9, w14, w_new;
  logic [31:0] t1, t2, ch, maj;

  // Window holds W[t] .. W[t+15], W[t] in the top word.
  assign w0  = win_r[511:480];
  assign w1  = win_r[479:448];
  assign w9  = win_r[223:192];
  assign w14 = win_r[63:32];
  assign w_new = w0 + sha256_pkg::small_sigma0(w1) + w9 + sha256_pkg::small_sigma1(w14);

  assign ch  = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
  assign maj = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]);
  assign t1  = work_r[7] + sha256_pkg::big_sigma1(work_r[4]) + ch
               + sha256_pkg::K_TAB[rnd_r] + w0;
  assign t2  = sha256_pkg::big_sigma0(work_r[0]) + maj;

  always_comb begin
    unique case (cmd.src)
      sha256_pkg::SRC_IN:   shift_byte = in_byte;
      sha256_pkg::SRC_PAD:  shift_byte = sha256_pkg::PAD_BYTE;
      sha256_pkg::SRC_ZERO: shift_byte = 8'h00;
      sha256_pkg::SRC_LEN:  shift_byte = len_r[63:56];
      default:              shift_byte = 8'h00;
    endcase
  end

  always_comb begin
    win_nxt       = win_r;
    fpos_nxt      = fpos_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    rnd_nxt       = rnd_r;
    work_nxt      = work_r;
    chain_nxt     = chain_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.shift_en) begin
      win_nxt  = {win_r[503:0], shift_byte};
      fpos_nxt = fpos_r + 1'b1;
      if (cmd.src == sha256_pkg::SRC_LEN) begin
        len_nxt = {len_r[55:0], 8'h00};
      end
    end
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if (cmd.len_load) begin
      len_nxt = {cnt_r, 3'b000};
      cnt_nxt = '0;
    end
    if (cmd.blk_start) begin
      work_nxt = chain_r;
      rnd_nxt  = '0;
    end
    if (cmd.round_en) begin
      win_nxt     = {win_r[479:0], w_new};
      rnd_nxt     = rnd_r + 1'b1;
      work_nxt[7] = work_r[6];
      work_nxt[6] = work_r[5];
      work_nxt[5] = work_r[4];
      work_nxt[4] = work_r[3] + t1;
      work_nxt[3] = work_r[2];
      work_nxt[2] = work_r[1];
      work_nxt[1] = work_r[0];
      work_nxt[0] = t1 + t2;
    end
    if (cmd.chain_add) begin
      for (int i = 0; i < 8; i++) begin
        chain_nxt[i] = chain_r[i] + work_r[i];
      end
    end
    if (cmd.emit) begin
      for (int i = 0; i < 8; i++) begin
        out_nxt[32*i +: 32] = chain_r[i];
      end
      chain_nxt     = sha256_pkg::H_INIT;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fpos_r      <= '0;
      cnt_r       <= '0;
      chain_r     <= sha256_pkg::H_INIT;
      out_valid_r <= 1'b0;
    end else begin
      fpos_r      <= fpos_nxt;
      cnt_r       <= cnt_nxt;
      chain_r     <= chain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    len_r  <= len_nxt;
    rnd_r  <= rnd_nxt;
    work_r <= work_nxt;
    out_r  <= out_nxt;
  end

  assign sts.fpos_last  = (fpos_r == sha256_pkg::LAST_POS);
  assign sts.fpos_len   = (fpos_r == sha256_pkg::LEN_POS);
  assign sts.round_last = (rnd_r == sha256_pkg::LAST_RND);
  assign sts.out_busy   = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/sha256_ctrl.sv -----
// Controller of the SHA-256 hasher: intake, padding sequence, compression, emit.
// Depends on sha256_pkg and the assertion header; drives sha256_dp.
`include "sha256_byte_stream_hasher_core_assert.svh"

module sha256_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tuser,
  input  logic                in_tlast,
  output logic                in_tready,
  output sha256_pkg::dp_cmd_t cmd,
  input  sha256_pkg::dp_sts_t sts
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PAD80 = 7'b0000010,
    ST_PADZ  = 7'b0000100,
    ST_PADL  = 7'b0001000,
    ST_COMP  = 7'b0010000,
    ST_ADD   = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    ret_nxt   = ret_r;
    in_tready = (state_r == ST_IDLE);

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser) begin
            cmd.shift_en = 1'b1;
            cmd.src      = sha256_pkg::SRC_IN;
            cmd.cnt_inc  = 1'b1;
            if (sts.fpos_last) begin
              cmd.blk_start = 1'b1;
              state_nxt     = ST_COMP;
              ret_nxt       = in_tlast ? ST_PAD80 : ST_IDLE;
            end else if (in_tlast) begin
              state_nxt = ST_PAD80;
            end
          end else if (in_tlast) begin
            state_nxt = ST_PAD80;
          end
        end
      end
      ST_PAD80: begin
        cmd.shift_en = 1'b1;
        cmd.src      = sha256_pkg::SRC_PAD;
        cmd.len_load = 1'b1;
        if (sts.fpos_last) begin
          cmd.blk_start = 1'b1;
          state_nxt     = ST_COMP;
          ret_nxt       = ST_PADZ;
        end else begin
          state_nxt = ST_PADZ;
        end
      end
      ST_PADZ: begin
        // Position 56 is reached only in the block that takes the length.
        if (sts.fpos_len) begin
          state_nxt = ST_PADL;
        end else begin
          cmd.shift_en = 1'b1;
          cmd.src      = sha256_pkg::SRC_ZERO;
          if (sts.fpos_last) begin
            cmd.blk_start = 1'b1;
            state_nxt     = ST_COMP;
            ret_nxt       = ST_PADZ;
          end
        end
      end
      ST_PADL: begin
        cmd.shift_en = 1'b1;
        cmd.src      = sha256_pkg::SRC_LEN;
        if (sts.fpos_last) begin
          cmd.blk_start = 1'b1;
          state_nxt     = ST_COMP;
          ret_nxt       = ST_EMIT;
        end
      end
      ST_COMP: begin
        cmd.round_en = 1'b1;
        if (sts.round_last) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.chain_add = 1'b1;
        state_nxt     = ret_r;
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  `SHA_ASSERT_IMPL(a_no_intake_in_round, clk, rst_n, in_tready, !cmd.round_en, "intake during round")
  `SHA_ASSERT_IMPL(a_emit_free, clk, rst_n, cmd.emit, !sts.out_busy, "digest overwritten")
  `SHA_ASSERT_NEXT(a_add_after_rounds, clk, rst_n, cmd.round_en && sts.round_last,
                   cmd.chain_add, "chain add missing")

endmodule

// ----- rtl/sha256_byte_stream_hasher_core.sv -----
// Top level of the SHA-256 byte stream hasher: streaming ports around controller and datapath.
// Depends on sha256_pkg, sha256_ctrl and sha256_dp.
//
//  channel | direction | transaction carries
//  --------+-----------+----------------------------------------------------
//  in_     | slave     | one message byte (tdata), byte-present flag (tuser),
//          |           | end of message (tlast)
//  out_    | master    | 256-bit digest, digest_word_0 in the lowest bits
//
// Sequence: a message byte is taken while in_tready is high; the byte that completes a
// 64-byte block starts a compression: the rounds on the single round unit, then a chain add.
// End of message adds byte-wise padding, one or two compressions and an emit before
// in_tready returns.
// Reset: synchronous active low; restores the initial chain and clears the byte count.
// Stalls: in_tready drops while padding, compressing, or holding a digest for a busy output.
module sha256_byte_stream_hasher_core (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] data_byte
  input  logic                         in_tuser,   // [0] has_byte
  input  logic                         in_tlast,   // last
  // Digest stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [sha256_pkg::DIG_W-1:0] out_tdata   // digest_word_0 [31:0] .. digest_word_7 [255:224]
);

  sha256_pkg::dp_cmd_t cmd;
  sha256_pkg::dp_sts_t sts;

  // Sequence intake, padding and compression.
  sha256_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Hold the block window, round state, chain words and the output register.
  sha256_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_byte   (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule
